// ===== rtl/arig_pkg.sv =====
// package: types, constants and register indexes for the ramp instruction generator
`default_nettype none
package arig_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam logic [15:0] LATENCY_TICKS = 16'd2;
    localparam logic signed [15:0] CODE_MAX = 16'sd32767;
    localparam logic signed [15:0] CODE_MIN = -16'sd32768;
    localparam int FULL_SCALE_MV = 10000;
    localparam int CODE_SCALE = 32767;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_STEP_SMALL = 2'd1;
    localparam logic [1:0] ST_FEW_POINTS = 2'd2;
    localparam logic [1:0] ST_CAPPED = 2'd3;

    localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
    localparam logic [1:0] REG_MIN_STEP_TICKS = 2'd1;
    localparam logic [1:0] REG_MIN_STEP_TIME = 2'd2;

    typedef struct packed {
        logic [15:0] step_time;
        logic [23:0] ramp_length;
        logic signed [15:0] v_start;
        logic signed [15:0] v_end;
    } arig_in_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic last;
        logic [1:0] status;
        logic time_clamped;
        logic volt_clamped;
    } arig_out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_NDIV, S_SETUP, S_POINT, S_PDIV, S_EMIT, S_ERR, S_WAIT
    } arig_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic start_ndiv;
        logic setup;
        logic point_calc;
        logic mag_calc;
        logic start_pdiv;
        logic emit;
        logic emit_err;
        logic next_point;
    } arig_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic step_bad;
        logic div_done;
        logic few_points;
        logic last_point;
    } arig_sts_t;
endpackage
`default_nettype wire

// ===== rtl/arig_div.sv =====
// radix-2 restoring divider for unsigned operands, one quotient bit per cycle
`default_nettype none
module arig_div import arig_pkg::*; #(
    parameter int W = 48
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0] rem_reg, rem_next, quo_reg, quo_next, dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [W:0] trial;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[W]) begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/arig_datapath.sv =====
// datapath: command registers, tick word, point arithmetic and result register
`default_nettype none
module arig_datapath import arig_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire arig_in_t    in_beat,
    input  wire logic [7:0]  ticks_per_us,
    input  wire logic [15:0] min_step_ticks,
    input  wire logic [15:0] min_step_time,
    input  wire arig_cmd_t   cmd,
    output arig_sts_t        sts,
    output arig_out_t        result
);
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int DW = 48;

    logic [15:0] step_reg;
    logic [23:0] len_reg;
    logic signed [15:0] vs_reg, ve_reg;
    logic [PW-1:0] n_reg, idx_reg;
    logic [1:0] status_reg;
    logic tc_reg, vc_reg, neg_reg;
    logic [15:0] tick_reg;
    logic signed [40:0] num_reg;   // vs*den + diff*i
    logic signed [40:0] limit_reg; // 10000*den
    logic signed [15:0] code_word;
    arig_out_t out_reg;

    logic div_start, div_done;
    logic [DW-1:0] div_a, div_b, div_q;
    logic [DW-1:0] mag_reg;

    arig_div #(.W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    assign div_start = cmd.start_ndiv | cmd.start_pdiv;
    always_comb begin
        if (cmd.start_ndiv) begin
            div_a = DW'(len_reg);
            div_b = DW'(step_reg);
        end else begin
            div_a = mag_reg;
            div_b = DW'(limit_reg);
        end
    end

    logic [23:0] ticks_raw;
    assign ticks_raw = (24'(step_reg) * 24'(ticks_per_us)) >> 4;

    logic signed [16:0] diff;
    assign diff = 17'(ve_reg) - 17'(vs_reg);
    logic signed [PW:0] den_s, idx_s;
    assign den_s = $signed({1'b0, n_reg - PW'(1)});
    assign idx_s = $signed({1'b0, idx_reg});
    logic signed [16+PW:0] prod_vs;
    logic signed [17+PW:0] prod_diff;
    assign prod_vs = vs_reg * den_s;
    assign prod_diff = diff * idx_s;
    logic signed [40:0] prod_num;
    assign prod_num = 41'(prod_vs) + 41'(prod_diff);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            step_reg <= in_beat.step_time;
            len_reg <= in_beat.ramp_length;
            vs_reg <= in_beat.v_start;
            ve_reg <= in_beat.v_end;
            idx_reg <= '0;
        end
        if (cmd.setup) begin
            if (div_q > DW'(MAX_POINTS)) begin
                n_reg <= PW'(MAX_POINTS);
                status_reg <= ST_CAPPED;
            end else begin
                n_reg <= div_q[PW-1:0];
                status_reg <= ST_OK;
            end
            if (ticks_raw > 24'hFFFF) begin
                tick_reg <= 16'hFFFF - LATENCY_TICKS;
                tc_reg <= 1'b1;
            end else if (ticks_raw[15:0] < min_step_ticks) begin
                tick_reg <= min_step_ticks - LATENCY_TICKS;
                tc_reg <= 1'b1;
            end else begin
                tick_reg <= ticks_raw[15:0] - LATENCY_TICKS;
                tc_reg <= 1'b0;
            end
        end
        if (cmd.point_calc) begin
            num_reg <= prod_num;
            limit_reg <= 41'(FULL_SCALE_MV) * 41'(den_s);
            vc_reg <= 1'b0;
        end
        if (cmd.next_point) idx_reg <= idx_reg + PW'(1);
    end

    // saturation and magnitude of the point numerator
    logic sat_hi, sat_lo;
    assign sat_hi = num_reg > limit_reg;
    assign sat_lo = num_reg < -limit_reg;
    logic [40:0] abs_num;
    assign abs_num = num_reg[40] ? 41'(-num_reg) : 41'(num_reg);

    // mag = |num|*32767 as shift and subtract, loaded in the cycle after point_calc
    always_ff @(posedge aclk) begin
        if (cmd.mag_calc) begin
            mag_reg <= (DW'(abs_num) << 15) - DW'(abs_num);
            neg_reg <= num_reg[40];
        end
    end

    always_comb begin
        if (sat_hi) code_word = CODE_MAX;
        else if (sat_lo) code_word = CODE_MIN;
        else if (neg_reg) code_word = 16'(-div_q[15:0]);
        else code_word = div_q[15:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_err) begin
            out_reg.instruction <= '0;
            out_reg.last <= 1'b1;
            out_reg.status <= sts.step_bad ? ST_STEP_SMALL : ST_FEW_POINTS;
            out_reg.time_clamped <= 1'b0;
            out_reg.volt_clamped <= 1'b0;
        end else if (cmd.emit) begin
            out_reg.instruction <= {tick_reg, code_word};
            out_reg.last <= sts.last_point;
            out_reg.status <= status_reg;
            out_reg.time_clamped <= tc_reg;
            out_reg.volt_clamped <= sat_hi | sat_lo | vc_reg;
        end
    end

    assign sts.step_bad = (step_reg == 16'd0) || (step_reg < min_step_time);
    assign sts.div_done = div_done;
    assign sts.few_points = div_q <= DW'(1);
    assign sts.last_point = (idx_reg + PW'(1)) == n_reg;
    assign result = out_reg;
endmodule
`default_nettype wire

// ===== rtl/arig_ctrl.sv =====
// controller: sequences one ramp command through the datapath
`default_nettype none
module arig_ctrl import arig_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire arig_sts_t sts,
    output arig_cmd_t      cmd
);
    arig_state_t state_reg, state_next;
    logic mv_reg, mv_next;
    logic fin_reg, fin_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg <= 1'b0;
            fin_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            fin_reg <= fin_next;
        end
    end

    logic slot_free;
    assign slot_free = !mv_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        mv_next = mv_reg && !m_ready;
        fin_next = fin_reg;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.step_bad) state_next = S_ERR;
                else begin
                    cmd.start_ndiv = 1'b1;
                    state_next = S_NDIV;
                end
            end
            S_NDIV: if (sts.div_done) begin
                if (sts.few_points) state_next = S_ERR;
                else begin
                    cmd.setup = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.point_calc = 1'b1;
                state_next = S_POINT;
            end
            S_POINT: begin
                // magnitude loads here
                cmd.mag_calc = 1'b1;
                state_next = S_PDIV;
            end
            S_PDIV: begin
                cmd.start_pdiv = 1'b1;
                state_next = S_EMIT;
                fin_next = 1'b0;
            end
            S_EMIT: if (sts.div_done || fin_reg) begin
                fin_next = 1'b1;
                if (slot_free) begin
                    cmd.emit = 1'b1;
                    mv_next = 1'b1;
                    fin_next = 1'b0;
                    if (sts.last_point) state_next = S_WAIT;
                    else begin
                        cmd.next_point = 1'b1;
                        state_next = S_SETUP;
                    end
                end
            end
            S_ERR: if (slot_free) begin
                cmd.emit_err = 1'b1;
                mv_next = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: if (!mv_reg || m_ready) begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = mv_reg;
endmodule
`default_nettype wire

// ===== rtl/analog_ramp_instruction_generator_top.sv =====
// top level of the analog ramp instruction generator
// usage:
//   s_ channel takes one ramp command beat (step time, ramp length, start and
//   end voltage); m_ channel gives the instruction beats of that ramp, the
//   final one flagged by last. a rejected command gives one beat with status
//   step too small or too few points.
//   configuration: write cfg_we with cfg_index 0 ticks_per_us, 1 min_step_ticks,
//   2 min_step_time, only while idle.
// sequencing:
//   one command at a time; the point count is one divide on the shared
//   restoring divider, then each point runs setup, product, magnitude, a
//   divide on the same divider, and emit. a step too small beat leaves
//   without any divide, a too few points beat after the point count divide.
// reset: aresetn low, synchronous; registers return to 160, 2, 16, block idle.
// stall: when m_ready is low the result register holds its beat and the next
//   point waits finished in the sequencer, nothing is lost.
`default_nettype none
module analog_ramp_instruction_generator_top import arig_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire arig_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output arig_out_t        m_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [7:0] tpu_reg;
    logic [15:0] mst_reg, mstime_reg;
    arig_cmd_t cmd;
    arig_sts_t sts;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg <= 8'd160;
            mst_reg <= 16'd2;
            mstime_reg <= 16'd16;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TICKS_PER_US: tpu_reg <= cfg_data[7:0];
                REG_MIN_STEP_TICKS: mst_reg <= cfg_data;
                REG_MIN_STEP_TIME: mstime_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    arig_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    arig_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_beat(s_data), .ticks_per_us(tpu_reg),
        .min_step_ticks(mst_reg), .min_step_time(mstime_reg), .cmd(cmd),
        .sts(sts), .result(m_data)
    );
endmodule
`default_nettype wire

// ===== rtl/arig_checker.sv =====
// port-level checker for the ramp instruction generator, bound to the top level
`default_nettype none
module arig_checker import arig_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire arig_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_STEP_SMALL || m_data.status == ST_FEW_POINTS)
        |-> m_data.last && m_data.instruction == 32'd0)
        else $error("error beat not single");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("command taken while ramp output pending");
endmodule

bind analog_ramp_instruction_generator_top arig_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire

// ===== test/arig_ramp_checker.sv =====
// ramp checker: predicts instruction beats from accepted commands and compares them
module arig_ramp_checker import arig_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire arig_in_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire arig_out_t m_data,
    input  wire logic      cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    output int             fail_count,
    output int             pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  ticks_per_us_q;
    logic [15:0] min_ticks_q;
    logic [15:0] min_time_q;
    arig_out_t   ramp_beats[$];

    task automatic report_mismatch(input string what, input arig_out_t got, input arig_out_t want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic expand_ramp(input arig_in_t cmd);
        longint n, den, diff, num, code, vs, ve, ticks;
        logic [15:0] tword;
        logic [1:0] st;
        logic tc, vc;
        arig_out_t b;
        st = ST_OK;
        tc = 1'b0;
        b = '0;
        b.last = 1'b1;
        if (cmd.step_time == 0 || cmd.step_time < min_time_q) begin
            b.status = ST_STEP_SMALL;
            ramp_beats.push_back(b);
            return;
        end
        n = longint'(cmd.ramp_length) / longint'(cmd.step_time);
        if (n <= 1) begin
            b.status = ST_FEW_POINTS;
            ramp_beats.push_back(b);
            return;
        end
        if (n > MAX_POINTS_DEF) begin
            n = MAX_POINTS_DEF;
            st = ST_CAPPED;
        end
        ticks = (longint'(cmd.step_time) * longint'(ticks_per_us_q)) >>> 4;
        if (ticks > 65535) begin
            ticks = 65535;
            tc = 1'b1;
        end else if (ticks < longint'(min_ticks_q)) begin
            ticks = min_ticks_q;
            tc = 1'b1;
        end
        tword = 16'(ticks) - LATENCY_TICKS;
        vs = longint'(cmd.v_start);
        ve = longint'(cmd.v_end);
        den = n - 1;
        diff = ve - vs;
        for (longint i = 0; i < n; i++) begin
            num = vs * den + diff * i;
            vc = 1'b0;
            if (num > FULL_SCALE_MV * den) begin
                code = 32767;
                vc = 1'b1;
            end else if (num < -FULL_SCALE_MV * den) begin
                code = -32768;
                vc = 1'b1;
            end else begin
                code = (num * CODE_SCALE) / (FULL_SCALE_MV * den);
            end
            b.instruction = {tword, 16'(code)};
            b.last = (i == n - 1);
            b.status = st;
            b.time_clamped = tc;
            b.volt_clamped = vc;
            ramp_beats.push_back(b);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_us_q <= 8'd160;
            min_ticks_q <= 16'd2;
            min_time_q <= 16'd16;
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TICKS_PER_US: ticks_per_us_q <= cfg_data[7:0];
                    REG_MIN_STEP_TICKS: min_ticks_q <= cfg_data;
                    REG_MIN_STEP_TIME: min_time_q <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expand_ramp(s_data);
            if (m_valid && m_ready) begin
                if (ramp_beats.size() == 0) begin
                    report_mismatch("unexpected beat", m_data, '0);
                end else begin
                    if (m_data !== ramp_beats[0]) report_mismatch("beat", m_data, ramp_beats[0]);
                    void'(ramp_beats.pop_front());
                end
            end
        end
        pending_beats <= ramp_beats.size();
    end
endmodule

// ===== test/analog_ramp_instruction_generator_top_tb.sv =====
// testbench top: drives ramp commands and configuration, gives the verdict
module analog_ramp_instruction_generator_top_tb import arig_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    arig_in_t s_data;
    arig_out_t m_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    int fail_count, pending_beats;

    analog_ramp_instruction_generator_top i_dut (.*);

    arig_ramp_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard limit for the worst case, with every ramp at 64 points
    // and long stalls on every beat
    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    // short gaps mostly, an occasional long one, sometimes none at all
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls on the result channel
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    // valid stays high into the next beat when there is no gap
    task automatic send_cmd(input arig_in_t cmd);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_data <= cmd;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for all beats, then a quiet stretch before touching config
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic arig_in_t make_cmd(input logic [15:0] st, input logic [23:0] len,
                                          input logic [15:0] vs, input logic [15:0] ve);
        arig_in_t c;
        c.step_time = st;
        c.ramp_length = len;
        c.v_start = vs;
        c.v_end = ve;
        return c;
    endfunction

    // mostly valid ramps with small point counts, some raw noise
    function automatic arig_in_t rand_cmd();
        arig_in_t c;
        int n;
        c = arig_in_t'(72'({$urandom, $urandom, $urandom}));
        if ($urandom_range(0, 9) < 8) begin
            c.step_time = $urandom_range(0, 9) < 7 ? 16'($urandom_range(16, 4000)) : 16'($urandom);
            if (c.step_time == 0) c.step_time = 16;
            n = $urandom_range(0, 9) < 8 ? $urandom_range(2, 12) : $urandom_range(0, 200);
            c.ramp_length = 24'(longint'(c.step_time) * n + $urandom_range(0, c.step_time - 1));
        end
        return c;
    endfunction

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_TICKS_PER_US;
        cfg_data = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config, special cases and field extremes
        send_cmd(make_cmd(16'd0, 24'd100, 16'sd0, 16'sd0));            // zero step
        send_cmd(make_cmd(16'd15, 24'd100, 16'sd0, 16'sd0));           // step below minimum
        send_cmd(make_cmd(16'd100, 24'd150, 16'sd0, 16'sd0));          // one point only
        send_cmd(make_cmd(16'd100, 24'd0, 16'sd0, 16'sd0));            // zero points
        send_cmd(make_cmd(16'd16, 24'd48, -16'sd32768, 16'sd32767));   // saturate both ends
        send_cmd(make_cmd(16'd16, 24'hFFFFFF, 16'sd10000, -16'sd10000)); // capped
        send_cmd(make_cmd(16'hFFFF, 24'hFFFFFF, 16'sd32767, -16'sd32768)); // ticks saturate
        send_cmd(make_cmd(16'd20, 24'd40, 16'sd9999, 16'sd10001));
        send_cmd(make_cmd(16'd32, 24'd96, -16'sd1, 16'sd1));
        drain();

        // extremes of configuration, tick count below latency wraps
        write_reg(REG_TICKS_PER_US, 16'd1);
        write_reg(REG_MIN_STEP_TICKS, 16'd0);
        write_reg(REG_MIN_STEP_TIME, 16'd0);
        send_cmd(make_cmd(16'd1, 24'd3, 16'sd5, -16'sd5));
        send_cmd(make_cmd(16'd0, 24'd3, 16'sd5, -16'sd5));
        send_cmd(make_cmd(16'd17, 24'd34, 16'sd5, -16'sd5));
        drain();
        write_reg(REG_TICKS_PER_US, 16'd0);
        write_reg(REG_MIN_STEP_TICKS, 16'hFFFF);
        write_reg(REG_MIN_STEP_TIME, 16'hFFFF);
        send_cmd(make_cmd(16'hFFFF, 24'hFFFFFF, -16'sd20000, 16'sd20000));
        send_cmd(make_cmd(16'hFFFE, 24'hFFFFFF, 16'sd0, 16'sd0));
        drain();
        write_reg(REG_TICKS_PER_US, 16'd255);
        write_reg(REG_MIN_STEP_TICKS, 16'd1);
        write_reg(REG_MIN_STEP_TIME, 16'd16);
        send_cmd(make_cmd(16'd4112, 24'd8224, 16'sd1, 16'sd2));
        drain();

        // random phases with random configuration
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_TICKS_PER_US, 16'($urandom_range(0, 255)));
            write_reg(REG_MIN_STEP_TICKS, 16'($urandom_range(0, 9) < 7 ? $urandom_range(0, 400)
                                                                     : $urandom));
            write_reg(REG_MIN_STEP_TIME, 16'($urandom_range(0, 40)));
            for (int k = 0; k < 30; k++) send_cmd(rand_cmd());
            drain();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
